// File: design/dec_pkg.sv
// Shared types, constants and helpers for the disc elastic collision block.
`timescale 1ns / 1ps
package dec_pkg;

    // Field widths of the Q16.16 operands and derived datapath widths.
    localparam int FIELD_W   = 32;
    localparam int RADIUS_W  = 31;
    localparam int DSQ_W     = 64;
    localparam int DMAG_W    = 66;
    localparam int HALF_W    = 33;
    localparam int NUM_W     = 98;
    // The correction never exceeds the relative speed, so 33 quotient bits suffice.
    localparam int DIV_STEPS = 33;
    localparam int MAG_W     = 34;
    localparam int SUM_W     = 36;
    // Six front stages, the divider, the rounding stage and the output stage.
    localparam int PIPE_DEPTH = DIV_STEPS + 8;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd327680;

    // One input request: two discs with position and velocity.
    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
    } t_in_item;

    // One result request: updated velocities and the contact flags.
    typedef struct packed {
        logic signed [31:0] new_first_vel_x;
        logic signed [31:0] new_first_vel_y;
        logic signed [31:0] new_second_vel_x;
        logic signed [31:0] new_second_vel_y;
        logic               contact;
        logic               degenerate;
    } t_out_item;

    // Saturate a two's complement sum to the signed 32-bit range.
    function automatic logic [FIELD_W-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [FIELD_W-1:0] r;
        if (!v[SUM_W-1] && (|v[SUM_W-2:FIELD_W-1])) begin
            r = 32'h7FFF_FFFF;
        end else if (v[SUM_W-1] && !(&v[SUM_W-2:FIELD_W-1])) begin
            r = 32'h8000_0000;
        end else begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/disc_elastic_collision.sv
// Top level of the equal-mass two-disc elastic collision pipeline.
// Stages: six arithmetic stages, 33 divider stages, rounding and output.
// Throughput is one request per cycle while no result is held; the 33-stage bit-per-stage divider sets the depth.
// A result held at the output stalls the whole pipeline in place; nothing is lost.
// Synchronous active-low reset clears all valid bits and sets the radius to 5.0.
`timescale 1ns / 1ps
module disc_elastic_collision
    import dec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_item            i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_item           o_data
);

    // Values that ride beside the divider.
    typedef struct packed {
        logic [FIELD_W-1:0] v1x;
        logic [FIELD_W-1:0] v1y;
        logic [FIELD_W-1:0] v2x;
        logic [FIELD_W-1:0] v2y;
        logic               contact;
        logic               degen;
        logic               negx;
        logic               negy;
    } t_side;

    logic                  w_adv;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [RADIUS_W-1:0]   r_radius;

    // Pipeline advances unless a finished result waits.
    assign w_adv   = !r_vld[PIPE_DEPTH-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    // Valid bits and the radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
            end
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    // Stage 1: differences and their magnitudes.
    logic [HALF_W-1:0] w_dx, w_dy, w_dvx, w_dvy;
    logic [HALF_W-1:0] w_adx, w_ady, w_advx, w_advy;
    always_comb begin
        w_dx   = {i_data.first_pos_x[31], i_data.first_pos_x}
               - {i_data.second_pos_x[31], i_data.second_pos_x};
        w_dy   = {i_data.first_pos_y[31], i_data.first_pos_y}
               - {i_data.second_pos_y[31], i_data.second_pos_y};
        w_dvx  = {i_data.first_vel_x[31], i_data.first_vel_x}
               - {i_data.second_vel_x[31], i_data.second_vel_x};
        w_dvy  = {i_data.first_vel_y[31], i_data.first_vel_y}
               - {i_data.second_vel_y[31], i_data.second_vel_y};
        w_adx  = w_dx[HALF_W-1]  ? (33'd0 - w_dx)  : w_dx;
        w_ady  = w_dy[HALF_W-1]  ? (33'd0 - w_dy)  : w_dy;
        w_advx = w_dvx[HALF_W-1] ? (33'd0 - w_dvx) : w_dvx;
        w_advy = w_dvy[HALF_W-1] ? (33'd0 - w_dvy) : w_dvy;
    end

    logic [FIELD_W-1:0] r1_ax, r1_ay, r1_avx, r1_avy, r1_diam;
    logic               r1_sx, r1_sy, r1_svx, r1_svy;
    logic [FIELD_W-1:0] r1_v1x, r1_v1y, r1_v2x, r1_v2y;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ax   <= w_adx[FIELD_W-1:0];
            r1_ay   <= w_ady[FIELD_W-1:0];
            r1_avx  <= w_advx[FIELD_W-1:0];
            r1_avy  <= w_advy[FIELD_W-1:0];
            r1_sx   <= w_dx[HALF_W-1];
            r1_sy   <= w_dy[HALF_W-1];
            r1_svx  <= w_dvx[HALF_W-1];
            r1_svy  <= w_dvy[HALF_W-1];
            r1_diam <= {r_radius, 1'b0};
            r1_v1x  <= i_data.first_vel_x;
            r1_v1y  <= i_data.first_vel_y;
            r1_v2x  <= i_data.second_vel_x;
            r1_v2y  <= i_data.second_vel_y;
        end
    end

    // Stage 2: squares and the dot product terms.
    logic [DSQ_W-1:0]   r2_x2, r2_y2, r2_d2, r2_px, r2_py;
    logic               r2_sgx, r2_sgy, r2_ltx, r2_lty, r2_sx, r2_sy;
    logic [FIELD_W-1:0] r2_ax, r2_ay;
    logic [FIELD_W-1:0] r2_v1x, r2_v1y, r2_v2x, r2_v2y;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_x2  <= r1_ax * r1_ax;
            r2_y2  <= r1_ay * r1_ay;
            r2_d2  <= r1_diam * r1_diam;
            r2_px  <= r1_avx * r1_ax;
            r2_py  <= r1_avy * r1_ay;
            r2_sgx <= r1_sx ^ r1_svx;
            r2_sgy <= r1_sy ^ r1_svy;
            r2_ltx <= r1_ax < r1_diam;
            r2_lty <= r1_ay < r1_diam;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_v1x <= r1_v1x;
            r2_v1y <= r1_v1y;
            r2_v2x <= r1_v2x;
            r2_v2y <= r1_v2y;
        end
    end

    // Stage 3: squared distance, contact test and signed dot product.
    logic [DSQ_W:0]    w_sum;
    logic [DMAG_W:0]   w_tx, w_ty;
    always_comb begin
        w_sum = {1'b0, r2_x2} + {1'b0, r2_y2};
        w_tx  = r2_sgx ? (67'd0 - {3'b0, r2_px}) : {3'b0, r2_px};
        w_ty  = r2_sgy ? (67'd0 - {3'b0, r2_py}) : {3'b0, r2_py};
    end

    logic [DSQ_W-1:0]   r3_dsq;
    logic               r3_contact, r3_sx, r3_sy;
    logic [DMAG_W:0]    r3_dot;
    logic [FIELD_W-1:0] r3_ax, r3_ay;
    logic [FIELD_W-1:0] r3_v1x, r3_v1y, r3_v2x, r3_v2y;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_dsq     <= w_sum[DSQ_W-1:0];
            r3_contact <= r2_ltx && r2_lty && (w_sum < {1'b0, r2_d2});
            r3_dot     <= w_tx + w_ty;
            r3_sx      <= r2_sx;
            r3_sy      <= r2_sy;
            r3_ax      <= r2_ax;
            r3_ay      <= r2_ay;
            r3_v1x     <= r2_v1x;
            r3_v1y     <= r2_v1y;
            r3_v2x     <= r2_v2x;
            r3_v2y     <= r2_v2y;
        end
    end

    // Stage 4: dot product magnitude, correction signs, degenerate test.
    logic [DMAG_W:0] w_dabs;
    assign w_dabs = r3_dot[DMAG_W] ? (67'd0 - r3_dot) : r3_dot;

    logic [DMAG_W-1:0]  r4_dmag;
    logic [DSQ_W-1:0]   r4_dsq;
    logic               r4_contact, r4_degen, r4_negx, r4_negy;
    logic [FIELD_W-1:0] r4_ax, r4_ay;
    logic [FIELD_W-1:0] r4_v1x, r4_v1y, r4_v2x, r4_v2y;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_dmag    <= w_dabs[DMAG_W-1:0];
            r4_dsq     <= r3_dsq;
            r4_contact <= r3_contact;
            r4_degen   <= r3_contact && (r3_dsq == '0);
            r4_negx    <= r3_dot[DMAG_W] ^ r3_sx;
            r4_negy    <= r3_dot[DMAG_W] ^ r3_sy;
            r4_ax      <= r3_ax;
            r4_ay      <= r3_ay;
            r4_v1x     <= r3_v1x;
            r4_v1y     <= r3_v1y;
            r4_v2x     <= r3_v2x;
            r4_v2y     <= r3_v2y;
        end
    end

    // Stage 5: numerator partial products, low and high halves.
    logic [DMAG_W-2:0] r5_xl, r5_xh, r5_yl, r5_yh;
    logic [DSQ_W-1:0]  r5_dsq;
    t_side             r5_side;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_xl           <= r4_dmag[HALF_W-1:0] * r4_ax;
            r5_xh           <= r4_dmag[DMAG_W-1:HALF_W] * r4_ax;
            r5_yl           <= r4_dmag[HALF_W-1:0] * r4_ay;
            r5_yh           <= r4_dmag[DMAG_W-1:HALF_W] * r4_ay;
            r5_dsq          <= r4_dsq;
            r5_side.v1x     <= r4_v1x;
            r5_side.v1y     <= r4_v1y;
            r5_side.v2x     <= r4_v2x;
            r5_side.v2y     <= r4_v2y;
            r5_side.contact <= r4_contact;
            r5_side.degen   <= r4_degen;
            r5_side.negx    <= r4_negx;
            r5_side.negy    <= r4_negy;
        end
    end

    // Stage 6: combine the partial products into the full numerators.
    logic [NUM_W-1:0] r6_numx, r6_numy;
    logic [DSQ_W-1:0] r6_dsq;
    t_side            r6_side;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_numx <= {33'd0, r5_xl} + {r5_xh, 33'd0};
            r6_numy <= {33'd0, r5_yl} + {r5_yh, 33'd0};
            r6_dsq  <= r5_dsq;
            r6_side <= r5_side;
        end
    end

    // Divider stages, with the side values delayed to match.
    logic [HALF_W-1:0] w_qx, w_qy;
    logic [DSQ_W-1:0]  w_remx, w_remy, w_dsq;

    dec_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_num_x (r6_numx),
        .i_num_y (r6_numy),
        .i_dsq   (r6_dsq),
        .o_q_x   (w_qx),
        .o_rem_x (w_remx),
        .o_q_y   (w_qy),
        .o_rem_y (w_remy),
        .o_dsq   (w_dsq)
    );

    t_side r_side [DIV_STEPS];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r6_side;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Rounding stage: halves round away from zero on the magnitude.
    logic [MAG_W-1:0] r7_mx, r7_my;
    t_side            r7_side;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_mx   <= {1'b0, w_qx}
                     + {33'd0, ({w_remx, 1'b0} >= {1'b0, w_dsq})};
            r7_my   <= {1'b0, w_qy}
                     + {33'd0, ({w_remy, 1'b0} >= {1'b0, w_dsq})};
            r7_side <= r_side[DIV_STEPS-1];
        end
    end

    // Output stage: apply the correction, saturate, or pass through.
    logic [SUM_W-1:0] w_ex1x, w_ex1y, w_ex2x, w_ex2y, w_mx, w_my;
    logic [SUM_W-1:0] w_n1x, w_n1y, w_n2x, w_n2y;
    logic             w_upd;
    always_comb begin
        w_ex1x = {{4{r7_side.v1x[31]}}, r7_side.v1x};
        w_ex1y = {{4{r7_side.v1y[31]}}, r7_side.v1y};
        w_ex2x = {{4{r7_side.v2x[31]}}, r7_side.v2x};
        w_ex2y = {{4{r7_side.v2y[31]}}, r7_side.v2y};
        w_mx   = {2'b0, r7_mx};
        w_my   = {2'b0, r7_my};
        w_n1x  = r7_side.negx ? (w_ex1x + w_mx) : (w_ex1x - w_mx);
        w_n2x  = r7_side.negx ? (w_ex2x - w_mx) : (w_ex2x + w_mx);
        w_n1y  = r7_side.negy ? (w_ex1y + w_my) : (w_ex1y - w_my);
        w_n2y  = r7_side.negy ? (w_ex2y - w_my) : (w_ex2y + w_my);
        w_upd  = r7_side.contact && !r7_side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_data.new_first_vel_x  <= w_upd ? sat32(w_n1x) : r7_side.v1x;
            o_data.new_first_vel_y  <= w_upd ? sat32(w_n1y) : r7_side.v1y;
            o_data.new_second_vel_x <= w_upd ? sat32(w_n2x) : r7_side.v2x;
            o_data.new_second_vel_y <= w_upd ? sat32(w_n2y) : r7_side.v2y;
            o_data.contact          <= r7_side.contact;
            o_data.degenerate       <= r7_side.degen;
        end
    end

endmodule

// File: design/dec_div.sv
// Pipelined restoring divider for the two correction components, one bit per stage.
`timescale 1ns / 1ps
module dec_div
    import dec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NUM_W-1:0]   i_num_x,
    input  logic [NUM_W-1:0]   i_num_y,
    input  logic [DSQ_W-1:0]   i_dsq,
    output logic [HALF_W-1:0]  o_q_x,
    output logic [DSQ_W-1:0]   o_rem_x,
    output logic [HALF_W-1:0]  o_q_y,
    output logic [DSQ_W-1:0]   o_rem_y,
    output logic [DSQ_W-1:0]   o_dsq
);

    // Partial remainder, numerator bits still to shift in, and quotient so far.
    typedef struct packed {
        logic [DSQ_W-1:0]  rem;
        logic [HALF_W-1:0] low;
        logic [HALF_W-1:0] q;
    } t_lane;

    // One restoring step: bring in the next bit and subtract when it fits.
    function automatic t_lane div_step(input t_lane a, input logic [DSQ_W-1:0] d);
        t_lane             r;
        logic [DSQ_W:0]    t;
        logic [DSQ_W:0]    s;
        logic              ge;
        t     = {a.rem, a.low[HALF_W-1]};
        s     = t - {1'b0, d};
        ge    = (t >= {1'b0, d});
        r.rem = ge ? s[DSQ_W-1:0] : t[DSQ_W-1:0];
        r.low = {a.low[HALF_W-2:0], 1'b0};
        r.q   = {a.q[HALF_W-2:0], ge};
        return r;
    endfunction

    t_lane            r_x   [DIV_STEPS];
    t_lane            r_y   [DIV_STEPS];
    logic [DSQ_W-1:0] r_d   [DIV_STEPS];
    t_lane            w_x0;
    t_lane            w_y0;

    // The quotient is below 2^33, so the top numerator bits start below the divisor.
    always_comb begin
        w_x0.rem = i_num_x[NUM_W-2:HALF_W];
        w_x0.low = i_num_x[HALF_W-1:0];
        w_x0.q   = '0;
        w_y0.rem = i_num_y[NUM_W-2:HALF_W];
        w_y0.low = i_num_y[HALF_W-1:0];
        w_y0.q   = '0;
    end

    // Stage chain, all stages advancing together.
    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_stage
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[k] <= div_step(w_x0, i_dsq);
                        r_y[k] <= div_step(w_y0, i_dsq);
                        r_d[k] <= i_dsq;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[k] <= div_step(r_x[k-1], r_d[k-1]);
                        r_y[k] <= div_step(r_y[k-1], r_d[k-1]);
                        r_d[k] <= r_d[k-1];
                    end
                end
            end
        end
    endgenerate

    assign o_q_x   = r_x[DIV_STEPS-1].q;
    assign o_rem_x = r_x[DIV_STEPS-1].rem;
    assign o_q_y   = r_y[DIV_STEPS-1].q;
    assign o_rem_y = r_y[DIV_STEPS-1].rem;
    assign o_dsq   = r_d[DIV_STEPS-1];

endmodule

// File: tb/collision_checker.sv
// Checker that predicts disc collision results and compares them with the block output.
`timescale 1ns / 1ps
module collision_checker
    import dec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_item            i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_item           i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [RADIUS_W-1:0] radius;
    t_out_item           expected_velocities[$];
    int                  mismatch_count;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] clamp_velocity(input logic signed [127:0] v);
        if (v > 128'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -128'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Rounded correction component: dot * dc / dsq, halves away from zero.
    function automatic logic signed [127:0] impulse_component(
        input logic [127:0] dot_mag, input logic dot_neg,
        input logic signed [127:0] dc, input logic [127:0] dsq);
        logic [127:0] dc_mag;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        dc_mag = (dc < 0) ? -dc : dc;
        num = dot_mag * dc_mag;
        quo = num / dsq;
        rem = num % dsq;
        if (rem >= dsq - rem) begin
            quo = quo + 1;
        end
        return (dot_neg != (dc < 0)) ? -$signed(quo) : $signed(quo);
    endfunction

    // Velocities after an equal-mass elastic collision of the two discs.
    function automatic t_out_item predict_collision(input t_in_item it,
                                                    input logic [RADIUS_W-1:0] rad);
        logic signed [127:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        logic signed [127:0] dx, dy, dot, ux, uy;
        logic [127:0] ax, ay, diam, dsq, dot_mag;
        t_out_item r;
        p1x = it.first_pos_x;  p1y = it.first_pos_y;
        v1x = it.first_vel_x;  v1y = it.first_vel_y;
        p2x = it.second_pos_x; p2y = it.second_pos_y;
        v2x = it.second_vel_x; v2y = it.second_vel_y;
        dx = p1x - p2x;
        dy = p1y - p2y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        diam = 128'(rad) * 2;
        r.new_first_vel_x  = it.first_vel_x;
        r.new_first_vel_y  = it.first_vel_y;
        r.new_second_vel_x = it.second_vel_x;
        r.new_second_vel_y = it.second_vel_y;
        r.contact    = 1'b0;
        r.degenerate = 1'b0;
        dsq = ax * ax + ay * ay;
        if (ax < diam && ay < diam && dsq < diam * diam) begin
            r.contact = 1'b1;
            if (dsq == 0) begin
                r.degenerate = 1'b1;
            end else begin
                dot = (v1x - v2x) * dx + (v1y - v2y) * dy;
                dot_mag = (dot < 0) ? -dot : dot;
                ux = impulse_component(dot_mag, dot < 0, dx, dsq);
                uy = impulse_component(dot_mag, dot < 0, dy, dsq);
                r.new_first_vel_x  = clamp_velocity(v1x - ux);
                r.new_first_vel_y  = clamp_velocity(v1y - uy);
                r.new_second_vel_x = clamp_velocity(v2x + ux);
                r.new_second_vel_y = clamp_velocity(v2y + uy);
            end
        end
        return r;
    endfunction

    // Track the radius, queue predictions on each input request, check each result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            radius <= RADIUS_RESET;
        end else begin
            if (i_cfg_we) begin
                radius <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_velocities.push_back(predict_collision(i_in_data, radius));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_velocities.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result with nothing expected: %h", i_out_data);
                    end
                end else begin
                    want = expected_velocities.pop_front();
                    if (want.new_first_vel_x !== i_out_data.new_first_vel_x
                        || want.new_first_vel_y !== i_out_data.new_first_vel_y
                        || want.new_second_vel_x !== i_out_data.new_second_vel_x
                        || want.new_second_vel_y !== i_out_data.new_second_vel_y
                        || want.contact !== i_out_data.contact
                        || want.degenerate !== i_out_data.degenerate) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected v1=(%0d,%0d) v2=(%0d,%0d) c=%b d=%b",
                                     want.new_first_vel_x, want.new_first_vel_y,
                                     want.new_second_vel_x, want.new_second_vel_y,
                                     want.contact, want.degenerate);
                            $display("          actual   v1=(%0d,%0d) v2=(%0d,%0d) c=%b d=%b",
                                     i_out_data.new_first_vel_x, i_out_data.new_first_vel_y,
                                     i_out_data.new_second_vel_x,
                                     i_out_data.new_second_vel_y,
                                     i_out_data.contact, i_out_data.degenerate);
                        end
                    end
                end
            end
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_velocities.size();
    end

    initial begin
        mismatch_count = 0;
        o_fail_count   = 0;
        o_pending      = 0;
    end

endmodule

// File: tb/testbench.sv
// Top of the disc collision testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import dec_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    t_in_item            i_data;
    logic                o_valid;
    logic                i_ready;
    t_out_item           o_data;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    int                  burst_left;
    int                  stall_mode;
    logic [RADIUS_W-1:0] radius_now;

    disc_elastic_collision dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    collision_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side stalls: one of four random stall modes.
    always @(posedge i_clk) begin
        if (cycle_count % 64 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ((cycle_count % 8) < 5);
        endcase
    end

    // Present one request and hold it until accepted; bursts end with a gap.
    task automatic send_pair(input t_in_item it);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    // Wait until every expected result has come back, then let the pipeline settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radius_now = value;
    endtask

    function automatic t_in_item make_pair(input logic signed [31:0] p1x, p1y, v1x, v1y,
                                           input logic signed [31:0] p2x, p2y, v2x, v2y);
        t_in_item it;
        it.first_pos_x = p1x;  it.first_pos_y = p1y;
        it.first_vel_x = v1x;  it.first_vel_y = v1y;
        it.second_pos_x = p2x; it.second_pos_y = p2y;
        it.second_vel_x = v2x; it.second_vel_y = v2y;
        return it;
    endfunction

    // Random offset that usually lands near the contact distance.
    function automatic logic signed [31:0] near_offset(input logic [RADIUS_W-1:0] rad);
        longint diam;
        diam = 2 * longint'(rad);
        if (diam == 0 || diam > 64'd1073741824 || $urandom_range(0, 7) == 0) begin
            return $urandom;
        end
        return 32'(longint'($urandom_range(0, 32'(2 * diam))) - diam);
    endfunction

    // Random velocity: full range, small, or extreme.
    function automatic logic signed [31:0] rand_velocity();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    task automatic random_pairs(input int count);
        logic signed [31:0] p1x, p1y;
        t_in_item it;
        repeat (count) begin
            p1x = $urandom;
            p1y = $urandom;
            if ($urandom_range(0, 19) == 0) begin
                it = make_pair(p1x, p1y, rand_velocity(), rand_velocity(),
                               p1x, p1y, rand_velocity(), rand_velocity());
            end else begin
                it = make_pair(p1x, p1y, rand_velocity(), rand_velocity(),
                               p1x + near_offset(radius_now), p1y + near_offset(radius_now),
                               rand_velocity(), rand_velocity());
            end
            send_pair(it);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        cycle_count = 0;
        stall_mode  = 0;
        burst_left  = 0;
        radius_now  = RADIUS_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs at the reset radius of 5.0.
        send_pair(make_pair(0, 0, 32'sh0001_0000, 0, 0, 0, -32'sh0001_0000, 0));
        send_pair(make_pair(0, 0, 32'sh0001_0000, 0, 32'sh0003_0000, 0,
                            -32'sh0001_0000, 0));
        send_pair(make_pair(0, 0, 5, 3, 32'sh0003_0000, 32'sh0004_0000, -7, 2));
        send_pair(make_pair(32'sh0100_0000, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sh0002_0000,
                            32'sh0002_0000, 32'h8000_0000, 32'h8000_0000));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF,
                            32'h8000_0000, 0, 1));
        send_pair(make_pair(0, 0, 3, 0, 2, 0, 0, 0));
        send_pair(make_pair(0, 0, 1, 1, 1, 1, 0, 0));
        send_pair(make_pair(32'sh000A_0000, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(32'sh0009_FFFF, 0, 0, 0, 0, 0, 32'h8000_0000, 0));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        random_pairs(200);

        // Zero radius: contact is impossible, even at zero distance.
        write_radius('0);
        send_pair(make_pair(0, 0, 1, 2, 0, 0, 3, 4));
        random_pairs(100);

        // Largest radius: nearly every pair touches, saturation is common.
        write_radius(31'h7FFF_FFFF);
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_pair(make_pair(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0,
                            32'h8000_0000, 0));
        send_pair(make_pair(5, 5, 1, 1, 5, 5, 2, 2));
        random_pairs(250);

        // Smallest nonzero radius: only tiny distances count.
        write_radius(31'd1);
        send_pair(make_pair(0, 0, 9, 9, 1, 0, 0, 0));
        send_pair(make_pair(0, 0, 9, 9, 1, 1, 0, 0));
        random_pairs(150);

        // A few random radii to finish.
        repeat (3) begin
            write_radius(($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                     : 31'($urandom_range(1, 32'h0040_0000)));
            random_pairs(150);
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
